FILE: rtl/core/ldf_pkg.sv
// ----------------------------------------------------------------------------
// ldf_pkg
// shared types, constants and lookup tables of the luma deblocking core
// ----------------------------------------------------------------------------
package ldf_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int LINES       = 4;
    localparam int TAPS        = 8;
    localparam int LINE_BITS   = SAMPLE_BITS * TAPS;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [TAPS-1:0]     line_t;
    typedef line_t [LINES-1:0]      seg_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_WEAK   = 2'd1,
        MODE_STRONG = 2'd2
    } mode_t;

    // decision results carried with the samples
    typedef struct packed {
        mode_t      mode;
        logic       ep;
        logic       eq;
        logic [4:0] tc;
    } ctl_t;

    function automatic logic [6:0] beta_lut(input logic [5:0] idx);
        logic [6:0] r;
        case (idx)
            6'd16: r = 7'd6;  6'd17: r = 7'd7;  6'd18: r = 7'd8;  6'd19: r = 7'd9;
            6'd20: r = 7'd10; 6'd21: r = 7'd11; 6'd22: r = 7'd12; 6'd23: r = 7'd13;
            6'd24: r = 7'd14; 6'd25: r = 7'd15; 6'd26: r = 7'd16; 6'd27: r = 7'd17;
            6'd28: r = 7'd18; 6'd29: r = 7'd20; 6'd30: r = 7'd22; 6'd31: r = 7'd24;
            6'd32: r = 7'd26; 6'd33: r = 7'd28; 6'd34: r = 7'd30; 6'd35: r = 7'd32;
            6'd36: r = 7'd34; 6'd37: r = 7'd36; 6'd38: r = 7'd38; 6'd39: r = 7'd40;
            6'd40: r = 7'd42; 6'd41: r = 7'd44; 6'd42: r = 7'd46; 6'd43: r = 7'd48;
            6'd44: r = 7'd50; 6'd45: r = 7'd52; 6'd46: r = 7'd54; 6'd47: r = 7'd56;
            6'd48: r = 7'd58; 6'd49: r = 7'd60; 6'd50: r = 7'd62; 6'd51: r = 7'd64;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] tc_lut(input logic [5:0] idx);
        logic [4:0] r;
        case (idx)
            6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26: r = 5'd1;
            6'd27, 6'd28, 6'd29, 6'd30: r = 5'd2;
            6'd31, 6'd32, 6'd33, 6'd34: r = 5'd3;
            6'd35, 6'd36, 6'd37: r = 5'd4;
            6'd38, 6'd39: r = 5'd5;
            6'd40, 6'd41: r = 5'd6;
            6'd42: r = 5'd7;  6'd43: r = 5'd8;  6'd44: r = 5'd9;  6'd45: r = 5'd10;
            6'd46: r = 5'd11; 6'd47: r = 5'd13; 6'd48: r = 5'd14; 6'd49: r = 5'd16;
            6'd50: r = 5'd18; 6'd51: r = 5'd20; 6'd52: r = 5'd22; 6'd53: r = 5'd24;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [11:0] iabs12(input logic signed [11:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic sample_t clip_px(input logic signed [11:0] v);
        sample_t r;
        if (v < 0) r = '0;
        else if (v > 12'sd255) r = '1;
        else r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    function automatic logic signed [11:0] clamp12(input logic signed [11:0] lo,
                                                    input logic signed [11:0] hi,
                                                    input logic signed [11:0] v);
        logic signed [11:0] r;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

endpackage

FILE: rtl/core/ldf_param.sv
// ----------------------------------------------------------------------------
// ldf_param
// stage 1: qp average, beta and tc lookup, second-derivative activity
// ----------------------------------------------------------------------------
module ldf_param (
    input  logic                    aclk,
    input  logic                    en,
    input  ldf_pkg::seg_t           seg_in,
    input  logic [1:0]              strength,
    input  logic [5:0]              qp_q,
    input  logic [5:0]              qp_p,
    input  logic signed [4:0]       beta_ofs,
    input  logic signed [4:0]       tc_ofs,
    output ldf_pkg::seg_t           seg_out,
    output logic [6:0]              beta_out,
    output logic [4:0]              tc_out,
    output logic                    bs_zero_out,
    output logic [9:0]              dp0_out,
    output logic [9:0]              dp3_out,
    output logic [9:0]              dq0_out,
    output logic [9:0]              dq3_out
);

    logic [1:0]         bs;
    logic [5:0]         qp;
    logic signed [8:0]  bidx;
    logic signed [8:0]  tidx;
    logic [5:0]         bidx_c;
    logic [5:0]         tidx_c;

    function automatic logic [9:0] curv(input ldf_pkg::sample_t a,
                                        input ldf_pkg::sample_t b,
                                        input ldf_pkg::sample_t c);
        logic signed [11:0] v;
        v = $signed({4'd0, c}) - ($signed({4'd0, b}) <<< 1) + $signed({4'd0, a});
        v = ldf_pkg::iabs12(v);
        return v[9:0];
    endfunction

    always_comb begin
        bs   = (strength == 2'd3) ? 2'd2 : strength;
        qp   = 6'((7'(qp_q) + 7'(qp_p) + 7'd1) >> 1);
        bidx = $signed({3'd0, qp}) + 9'(beta_ofs);
        tidx = $signed({3'd0, qp}) + $signed({6'd0, bs, 1'b0}) - 9'sd2 + 9'(tc_ofs);
        if (bidx < 0) bidx_c = '0;
        else if (bidx > 9'sd51) bidx_c = 6'd51;
        else bidx_c = bidx[5:0];
        if (tidx < 0) tidx_c = '0;
        else if (tidx > 9'sd53) tidx_c = 6'd53;
        else tidx_c = tidx[5:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seg_out     <= seg_in;
            beta_out    <= ldf_pkg::beta_lut(bidx_c);
            tc_out      <= ldf_pkg::tc_lut(tidx_c);
            bs_zero_out <= (bs == 2'd0);
            dp0_out     <= curv(seg_in[0][3], seg_in[0][2], seg_in[0][1]);
            dp3_out     <= curv(seg_in[3][3], seg_in[3][2], seg_in[3][1]);
            dq0_out     <= curv(seg_in[0][4], seg_in[0][5], seg_in[0][6]);
            dq3_out     <= curv(seg_in[3][4], seg_in[3][5], seg_in[3][6]);
        end
    end

endmodule

FILE: rtl/core/ldf_decide.sv
// ----------------------------------------------------------------------------
// ldf_decide
// stage 2: filter on/off, strong/weak choice and side flags
// ----------------------------------------------------------------------------
module ldf_decide (
    input  logic           aclk,
    input  logic           en,
    input  ldf_pkg::seg_t  seg_in,
    input  logic [6:0]     beta,
    input  logic [4:0]     tc,
    input  logic           bs_zero,
    input  logic [9:0]     dp0,
    input  logic [9:0]     dp3,
    input  logic [9:0]     dq0,
    input  logic [9:0]     dq3,
    output ldf_pkg::seg_t  seg_out,
    output ldf_pkg::ctl_t  ctl_out
);

    logic [11:0]    d;
    logic [8:0]     side;
    logic [6:0]     tc25;
    logic           s0;
    logic           s3;
    ldf_pkg::ctl_t  ctl;

    function automatic logic strong_ok(input ldf_pkg::line_t s, input logic [10:0] dpq,
                                       input logic [6:0] b, input logic [6:0] t25);
        logic signed [11:0] a;
        logic signed [11:0] c;
        logic signed [11:0] e;
        a = ldf_pkg::iabs12($signed({4'd0, s[0]}) - $signed({4'd0, s[3]}));
        c = ldf_pkg::iabs12($signed({4'd0, s[4]}) - $signed({4'd0, s[7]}));
        e = ldf_pkg::iabs12($signed({4'd0, s[3]}) - $signed({4'd0, s[4]}));
        return ({dpq, 1'b0} < 12'(b >> 2)) && ((a + c) < $signed(12'(b >> 3)))
            && (e < $signed(12'(t25)));
    endfunction

    always_comb begin
        d    = 12'(dp0) + 12'(dq0) + 12'(dp3) + 12'(dq3);
        side = 9'((8'(beta) + 8'(beta >> 1)) >> 3);
        tc25 = 7'((8'(tc) * 8'd5 + 8'd1) >> 1);
        s0   = strong_ok(seg_in[0], 11'(dp0) + 11'(dq0), beta, tc25);
        s3   = strong_ok(seg_in[3], 11'(dp3) + 11'(dq3), beta, tc25);
        ctl.tc   = tc;
        ctl.mode = ldf_pkg::MODE_NONE;
        ctl.ep   = 1'b0;
        ctl.eq   = 1'b0;
        if (!bs_zero && (d < 12'(beta))) begin
            ctl.mode = (s0 && s3) ? ldf_pkg::MODE_STRONG : ldf_pkg::MODE_WEAK;
            ctl.ep   = (11'(dp0) + 11'(dp3)) < 11'(side);
            ctl.eq   = (11'(dq0) + 11'(dq3)) < 11'(side);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seg_out <= seg_in;
            ctl_out <= ctl;
        end
    end

endmodule

FILE: rtl/core/ldf_line_filter.sv
// ----------------------------------------------------------------------------
// ldf_line_filter
// stage 3: weak and strong filter of one line, result registered
// ----------------------------------------------------------------------------
module ldf_line_filter (
    input  logic            aclk,
    input  logic            en,
    input  ldf_pkg::line_t  line_in,
    input  ldf_pkg::ctl_t   ctl,
    output ldf_pkg::line_t  line_out
);

    typedef logic signed [11:0] v_t;

    v_t p3, p2, p1, p0, q0, q1, q2, q3;
    v_t t2, tcv, h, delta, dcl, dp, dq;
    // 9 and 3 times a full-range step needs more than twelve bits
    logic signed [13:0] raw;
    ldf_pkg::line_t res;

    function automatic v_t asr1(input v_t v);
        return v >>> 1;
    endfunction

    always_comb begin
        p3 = $signed({4'd0, line_in[0]}); p2 = $signed({4'd0, line_in[1]});
        p1 = $signed({4'd0, line_in[2]}); p0 = $signed({4'd0, line_in[3]});
        q0 = $signed({4'd0, line_in[4]}); q1 = $signed({4'd0, line_in[5]});
        q2 = $signed({4'd0, line_in[6]}); q3 = $signed({4'd0, line_in[7]});
        tcv = $signed({7'd0, ctl.tc});
        t2  = tcv <<< 1;
        h   = tcv >>> 1;
        res = line_in;
        raw = (((q0 - p0) <<< 3) + (q0 - p0)) - (((q1 - p1) <<< 1) + (q1 - p1)) + 14'sd8;
        delta = v_t'(raw >>> 4);
        dcl = ldf_pkg::clamp12(-tcv, tcv, delta);
        dp  = ldf_pkg::clamp12(-h, h, asr1(((p2 + p0 + 12'sd1) >>> 1) - p1 + dcl));
        dq  = ldf_pkg::clamp12(-h, h, asr1(((q2 + q0 + 12'sd1) >>> 1) - q1 - dcl));
        case (ctl.mode)
            ldf_pkg::MODE_STRONG: begin
                res[3] = 8'(ldf_pkg::clamp12(p0 - t2, p0 + t2,
                    (p2 + (p1 <<< 1) + (p0 <<< 1) + (q0 <<< 1) + q1 + 12'sd4) >>> 3));
                res[2] = 8'(ldf_pkg::clamp12(p1 - t2, p1 + t2,
                    (p2 + p1 + p0 + q0 + 12'sd2) >>> 2));
                res[1] = 8'(ldf_pkg::clamp12(p2 - t2, p2 + t2,
                    ((p3 <<< 1) + (p2 <<< 1) + p2 + p1 + p0 + q0 + 12'sd4) >>> 3));
                res[4] = 8'(ldf_pkg::clamp12(q0 - t2, q0 + t2,
                    (p1 + (p0 <<< 1) + (q0 <<< 1) + (q1 <<< 1) + q2 + 12'sd4) >>> 3));
                res[5] = 8'(ldf_pkg::clamp12(q1 - t2, q1 + t2,
                    (p0 + q0 + q1 + q2 + 12'sd2) >>> 2));
                res[6] = 8'(ldf_pkg::clamp12(q2 - t2, q2 + t2,
                    (p0 + q0 + q1 + (q2 <<< 1) + q2 + (q3 <<< 1) + 12'sd4) >>> 3));
            end
            ldf_pkg::MODE_WEAK: begin
                if (ldf_pkg::iabs12(delta) < ((tcv <<< 3) + (tcv <<< 1))) begin
                    res[3] = ldf_pkg::clip_px(p0 + dcl);
                    res[4] = ldf_pkg::clip_px(q0 - dcl);
                    if (ctl.ep) res[2] = ldf_pkg::clip_px(p1 + dp);
                    if (ctl.eq) res[5] = ldf_pkg::clip_px(q1 + dq);
                end
            end
            default: res = line_in;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            line_out <= res;
        end
    end

endmodule

FILE: rtl/core/luma_deblocking_edge_filter_core.sv
// ----------------------------------------------------------------------------
// luma_deblocking_edge_filter_core
// luma deblocking of one four-line, eight-tap edge segment per word
// ----------------------------------------------------------------------------
// usage
//   s_axis side takes one edge segment per word: four lines of eight samples
//   plus strength, both qps and the slice beta and tc offsets
//   m_axis side gives the four filtered lines and the chosen filter mode
//   three register stages: the result word is valid once it has been
//   registered by all three; throughput is one word per clock unless
//   m_tready stalls; the pipeline holds up to three words
//   the three register stages are parameter lookup, filter decision and
//   line filtering; all four lines are filtered in parallel in the last
//   a stall on m_tready freezes all stages together; s_tready drops only
//   while the output stage is full and not being taken, so nothing is lost
//   or repeated
//   aresetn (synchronous, active low) clears all stage valid bits; the
//   payload registers keep whatever they held
// ----------------------------------------------------------------------------
module luma_deblocking_edge_filter_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // line_zero[63:0], line_one[127:64], line_two[191:128], line_three[255:192],
    // strength[257:256], qp_q_side[263:258], qp_p_side[269:264],
    // beta_shift[274:270], tc_shift[279:275]
    input  logic [279:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_line_zero[63:0] .. out_line_three[255:192], filter_mode[257:256]
    output logic [263:0] m_tdata
);

    // pipeline advances when the output stage is empty or being taken
    logic en;
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;

    ldf_pkg::seg_t seg_in;
    ldf_pkg::seg_t seg1, seg2, seg3;
    ldf_pkg::ctl_t ctl2;
    ldf_pkg::mode_t mode_reg;
    logic [6:0] beta1;
    logic [4:0] tc1;
    logic       bz1;
    logic [9:0] dp0, dp3, dq0, dq3;

    assign en       = !v3_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = v3_reg;

    assign seg_in = s_tdata[255:0];

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (en) begin
            v1_next = s_tvalid;
            v2_next = v1_reg;
            v3_next = v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: tables and activity
    ldf_param u_param (
        .aclk        (aclk),
        .en          (en),
        .seg_in      (seg_in),
        .strength    (s_tdata[257:256]),
        .qp_q        (s_tdata[263:258]),
        .qp_p        (s_tdata[269:264]),
        .beta_ofs    ($signed(s_tdata[274:270])),
        .tc_ofs      ($signed(s_tdata[279:275])),
        .seg_out     (seg1),
        .beta_out    (beta1),
        .tc_out      (tc1),
        .bs_zero_out (bz1),
        .dp0_out     (dp0),
        .dp3_out     (dp3),
        .dq0_out     (dq0),
        .dq3_out     (dq3)
    );

    // stage 2: mode decision
    ldf_decide u_decide (
        .aclk    (aclk),
        .en      (en),
        .seg_in  (seg1),
        .beta    (beta1),
        .tc      (tc1),
        .bs_zero (bz1),
        .dp0     (dp0),
        .dp3     (dp3),
        .dq0     (dq0),
        .dq3     (dq3),
        .seg_out (seg2),
        .ctl_out (ctl2)
    );

    // stage 3: per-line filters
    for (genvar k = 0; k < ldf_pkg::LINES; k++) begin : g_line
        ldf_line_filter u_line (
            .aclk     (aclk),
            .en       (en),
            .line_in  (seg2[k]),
            .ctl      (ctl2),
            .line_out (seg3[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg <= ctl2.mode;
        end
    end

    assign m_tdata = {6'd0, mode_reg, seg3};

endmodule
